// ===== src/sha256_stream_hasher_macros.svh =====
// assertion helpers used by the hasher top file
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shs same-cycle check failed");

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shs next-cycle check failed");

`endif

// ===== src/shs_pkg.sv =====
`timescale 1ns / 1ps

package shs_pkg;

	typedef logic [0:7][31:0] hash_t;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
		logic        length_overflow;
	} out_item_t;

	typedef struct packed {
		logic start;
	} core_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_status_t;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam hash_t IV_256 = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam hash_t IV_224 = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== src/shs_round_core.sv =====
`timescale 1ns / 1ps

module shs_round_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shs_pkg::core_ctrl_t  ctrl,
	input  logic [31:0]          w_word,
	input  shs_pkg::hash_t       hash_in,
	output shs_pkg::core_status_t status,
	output shs_pkg::hash_t       work
);
	import shs_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  round_q;
	hash_t       work_q;
	hash_t       work_next;

	// one compression round per cycle
	always_comb begin
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] ch;
		logic [31:0] maj;
		ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1  = work_q[7] + big_sigma1(work_q[4]) + ch + ROUND_K[round_q] + w_word;
		t2  = big_sigma0(work_q[0]) + maj;
		work_next[0] = t1 + t2;
		work_next[1] = work_q[0];
		work_next[2] = work_q[1];
		work_next[3] = work_q[2];
		work_next[4] = work_q[3] + t1;
		work_next[5] = work_q[4];
		work_next[6] = work_q[5];
		work_next[7] = work_q[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= hash_in;
		end else if (busy_q) begin
			work_q <= work_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign work        = work_q;

endmodule

// ===== src/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data (word, valid bytes, last)
// out     | output    | out_valid / out_ready | out_data (digest word, last, overflow)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (digest mode)
//
// a word that does not close a block is taken without holding off input; the word that fills
// a block holds off input while the round unit runs its compression rounds
// a final word is followed by padding words and one or two compressions,
// then 8 or 7 digest words leave through the output register, one per cycle while out_ready allows
// reset loads the SHA-256 initial hash; no memory clearing pass is needed
// a stalled output only holds the digest phase; the next message may start
// once the last digest word sits in the output register
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  shs_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output shs_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import shs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAIL,
		ST_COMP,
		ST_OUT
	} state_t;

	state_t       state_q;
	logic         mode_q;
	hash_t        hash_q;
	logic [3:0]   fill_q;
	logic [31:0]  total_q;
	logic         ovf_q;
	logic         tail_q;
	logic         pad_pend_q;
	logic         len_q;
	logic         msg_done_q;
	logic         start_q;
	logic [2:0]   out_cnt_q;
	logic         out_valid_q;
	out_item_t    out_data_q;
	logic [31:0]  sched_q [16];

	core_ctrl_t   core_ctrl;
	core_status_t core_st;
	hash_t        core_work;

	logic         in_acc;
	logic         push_en;
	logic [31:0]  push_word;
	logic         push_pad;
	logic         push_len_hi;
	logic         push_len_lo;
	logic [2:0]   byte_cnt;
	logic [32:0]  byte_sum;
	logic [31:0]  last_masked;
	logic [2:0]   out_last_idx;
	logic         out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign core_ctrl.start = start_q;
	assign out_last_idx = mode_q ? 3'd6 : 3'd7;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// byte count and trailing-byte mask of the final word
	always_comb begin
		logic [2:0] vb;
		vb = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
		byte_cnt = in_data.last_word ? vb : 3'd4;
		byte_sum = {1'b0, total_q} + 33'(byte_cnt);
		case (vb)
			3'd0:    last_masked = PAD_WORD;
			3'd1:    last_masked = {in_data.message_word[31:24], PAD_BYTE, 16'h0};
			3'd2:    last_masked = {in_data.message_word[31:16], PAD_BYTE, 8'h0};
			3'd3:    last_masked = {in_data.message_word[31:8], PAD_BYTE};
			default: last_masked = in_data.message_word;
		endcase
	end

	// word entering the block buffer this cycle
	always_comb begin
		push_en     = 1'b0;
		push_word   = '0;
		push_pad    = 1'b0;
		push_len_hi = 1'b0;
		push_len_lo = 1'b0;
		if (in_acc) begin
			push_en   = 1'b1;
			push_word = in_data.last_word ? last_masked : in_data.message_word;
		end else if (state_q == ST_TAIL) begin
			push_en = 1'b1;
			if (pad_pend_q) begin
				push_pad  = 1'b1;
				push_word = PAD_WORD;
			end else if (fill_q == 4'd14) begin
				push_len_hi = 1'b1;
				push_word   = {29'b0, total_q[31:29]};
			end else if (fill_q == 4'd15 && len_q) begin
				push_len_lo = 1'b1;
				push_word   = {total_q[28:0], 3'b000};
			end
		end
	end

	// block buffer doubles as the message schedule window
	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= push_word;
		end else if (core_st.busy) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= sched_q[0] + small_sigma0(sched_q[1]) + sched_q[9]
				+ small_sigma1(sched_q[14]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			hash_q      <= IV_256;
			fill_q      <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			tail_q      <= 1'b0;
			pad_pend_q  <= 1'b0;
			len_q       <= 1'b0;
			msg_done_q  <= 1'b0;
			start_q     <= 1'b0;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				if (byte_sum[32]) begin
					total_q <= '1;
					ovf_q   <= 1'b1;
				end else begin
					total_q <= byte_sum[31:0];
				end
				if (in_data.last_word) begin
					tail_q     <= 1'b1;
					pad_pend_q <= (byte_cnt == 3'd4);
				end
			end
			if (push_pad) begin
				pad_pend_q <= 1'b0;
			end
			if (push_len_hi) begin
				len_q <= 1'b1;
			end
			if (push_len_lo) begin
				msg_done_q <= 1'b1;
			end

			if (push_en) begin
				fill_q <= fill_q + 4'd1;
				if (fill_q == 4'd15) begin
					state_q <= ST_COMP;
					start_q <= 1'b1;
				end else if (in_acc && in_data.last_word) begin
					state_q <= ST_TAIL;
				end
			end

			case (state_q)
				ST_COMP: begin
					if (core_st.done) begin
						for (int i = 0; i < 8; i++) begin
							hash_q[i] <= hash_q[i] + core_work[i];
						end
						if (msg_done_q) begin
							state_q   <= ST_OUT;
							out_cnt_q <= '0;
						end else if (tail_q) begin
							state_q <= ST_TAIL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q                <= 1'b1;
						out_data_q.digest_word     <= hash_q[0];
						out_data_q.digest_last     <= (out_cnt_q == out_last_idx);
						out_data_q.length_overflow <= ovf_q;
						out_cnt_q                  <= out_cnt_q + 3'd1;
						for (int i = 0; i < 7; i++) begin
							hash_q[i] <= hash_q[i + 1];
						end
						hash_q[7] <= '0;
						if (out_cnt_q == out_last_idx) begin
							// message finished: back to the initial hash
							state_q    <= ST_IDLE;
							hash_q     <= mode_q ? IV_224 : IV_256;
							fill_q     <= '0;
							total_q    <= '0;
							ovf_q      <= 1'b0;
							tail_q     <= 1'b0;
							pad_pend_q <= 1'b0;
							len_q      <= 1'b0;
							msg_done_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				mode_q     <= cfg_data;
				hash_q     <= cfg_data ? IV_224 : IV_256;
				fill_q     <= '0;
				total_q    <= '0;
				ovf_q      <= 1'b0;
				tail_q     <= 1'b0;
				pad_pend_q <= 1'b0;
				len_q      <= 1'b0;
				msg_done_q <= 1'b0;
			end
		end
	end

	shs_round_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (core_ctrl),
		.w_word  (sched_q[0]),
		.hash_in (hash_q),
		.status  (core_st),
		.work    (core_work)
	);

	`SHS_ASSERT_NOW(a_ready_core_idle, clk, arst_n, in_ready, !core_st.busy)
	`SHS_ASSERT_NEXT(a_start_runs, clk, arst_n, start_q, core_st.busy)
	`SHS_ASSERT_NEXT(a_fill_held, clk, arst_n, (state_q == ST_COMP) && !core_st.done, $stable(fill_q))
	`SHS_ASSERT_NOW(a_out_after_len, clk, arst_n, state_q == ST_OUT, msg_done_q && (fill_q == 4'd0))

endmodule
